// File: rtl/fasmd_pkg.sv
// ----------------------------------------------------------------------------
// fasmd_pkg
// shared types, codes and helpers of the binary32 / binary16 arithmetic unit
// ----------------------------------------------------------------------------
package fasmd_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CLS_FIN  = 2'd0,
    CLS_ZERO = 2'd1,
    CLS_INF  = 2'd2,
    CLS_NAN  = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    RM_RTZ = 2'd0,
    RM_RNE = 2'd1,
    RM_RUP = 2'd2,
    RM_RDN = 2'd3
  } rm_t;

  localparam logic REG_FMT = 1'b0;
  localparam logic REG_RND = 1'b1;

  localparam int EXP_W      = 11;
  localparam int SIG_W      = 24;
  localparam int Q_W        = 29;
  localparam int DIV_STAGES = 7;
  localparam int DIV_STEPS  = 4;
  localparam int NST        = 15;

  localparam logic signed [EXP_W-1:0] BIAS32 = 11'sd127;
  localparam logic signed [EXP_W-1:0] BIAS16 = 11'sd15;
  localparam logic signed [EXP_W-1:0] EMIN32 = -11'sd126;
  localparam logic signed [EXP_W-1:0] EMIN16 = -11'sd14;

  typedef struct packed {
    cls_t                     cls;
    logic                     sign;
    logic signed [EXP_W-1:0]  exp;
    logic [SIG_W-1:0]         sig;
  } op_t;

  function automatic logic [4:0] lzc23(input logic [22:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd0;
    found = 1'b0;
    for (int i = 22; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 5'd1;
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] msb25(input logic [24:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 25; i++) begin
      if (v[i]) p = i[4:0];
    end
    return p;
  endfunction

  // significand normalized to a leading one at bit 23 in both formats
  function automatic op_t decode(input logic [31:0] raw, input logic fmt);
    op_t                     o;
    logic [22:0]             fr;
    logic [7:0]              ef;
    logic                    emax;
    logic signed [EXP_W-1:0] bias;
    logic signed [EXP_W-1:0] emin;
    logic [4:0]              lz;
    if (fmt) begin
      fr   = raw[22:0];
      ef   = raw[30:23];
      o.sign = raw[31];
      emax = &raw[30:23];
      bias = BIAS32;
      emin = EMIN32;
    end else begin
      fr   = {raw[9:0], 13'd0};
      ef   = {3'd0, raw[14:10]};
      o.sign = raw[15];
      emax = &raw[14:10];
      bias = BIAS16;
      emin = EMIN16;
    end
    lz    = lzc23(fr);
    o.exp = '0;
    o.sig = '0;
    if (emax) begin
      o.cls = (fr != 23'd0) ? CLS_NAN : CLS_INF;
    end else if (ef == 8'd0) begin
      if (fr == 23'd0) begin
        o.cls = CLS_ZERO;
      end else begin
        o.cls = CLS_FIN;
        o.sig = {fr, 1'b0} << lz;
        o.exp = emin - $signed({6'd0, lz}) - 11'sd1;
      end
    end else begin
      o.cls = CLS_FIN;
      o.sig = {1'b1, fr};
      o.exp = $signed({3'd0, ef}) - bias;
    end
    return o;
  endfunction

endpackage

// File: rtl/float_add_sub_mul_div.sv
// ----------------------------------------------------------------------------
// float_add_sub_mul_div
// pipelined binary32 / binary16 add, subtract, multiply and divide
// ----------------------------------------------------------------------------
//  channel | signals                                 | direction
//  in      | in_valid, in_stall, cmd, operand_a/b     | word in
//  out     | out_valid, out_stall, result_*           | word out
//  cfg     | cfg_write, cfg_index, cfg_data           | register write
//
//  fifteen register stages, one word per cycle sustained while out_stall is low
//  the divider takes 4 quotient bits per stage over 7 stages and sets the depth
//  each stage moves when the next one is empty or moving, so bubbles close up
//  rst is synchronous, clears the valid bits and sets the config to binary32, RNE
// ----------------------------------------------------------------------------
module float_add_sub_mul_div
  import fasmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_class,
  output logic        result_sign,
  output logic signed [8:0] result_exponent,
  output logic [22:0] result_fraction,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);

  typedef struct packed {
    cmd_t                    cmd;
    cls_t                    ca;
    cls_t                    cb;
    logic                    sa;
    logic                    sb;
    logic signed [EXP_W-1:0] ea;
    logic signed [EXP_W-1:0] eb;
    logic [SIG_W-1:0]        ma;
    logic [SIG_W-1:0]        mb;
  } dec_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic                    spec;
    cls_t                    scls;
    logic                    ssign;
    logic                    sign;
    logic                    sub;
    logic signed [EXP_W-1:0] e;
    logic [5:0]              d;
    logic [48:0]             acc;
    logic [47:0]             y;
    logic [SIG_W-1:0]        dvs;
    logic [SIG_W-1:0]        rem;
    logic [Q_W-1:0]          quo;
  } mid_t;

  typedef struct packed {
    logic                    spec;
    cls_t                    scls;
    logic                    ssign;
    logic                    sign;
    logic signed [EXP_W-1:0] e;
    logic [63:0]             n;
  } nrm_t;

  typedef struct packed {
    logic                    spec;
    cls_t                    scls;
    logic                    ssign;
    logic                    sign;
    logic                    sub;
    logic signed [EXP_W-1:0] e;
    logic [23:0]             kept;
    logic                    inc;
  } rnd_t;

  typedef struct packed {
    logic                    spec;
    cls_t                    scls;
    logic                    ssign;
    logic                    sign;
    logic                    sub;
    logic                    ovf;
    logic signed [EXP_W-1:0] e;
    logic [24:0]             k2;
    logic [4:0]              p;
  } fin_t;

  logic number_format;
  rm_t  rounding_mode;

  logic [NST-1:0] vld;
  logic [NST-1:0] adv;
  logic [NST-1:0] vld_in;

  dec_t s1, s1_next;
  mid_t s2, s2_next;
  mid_t mid_q  [DIV_STAGES];
  mid_t mid_d  [DIV_STAGES];
  mid_t mid_in [DIV_STAGES];
  nrm_t s10, s10_next, s11, s11_next, s12, s12_next;
  rnd_t s13, s13_next;
  fin_t s14, s14_next;

  logic [4:0]              fw;
  logic signed [EXP_W-1:0] emin;
  logic signed [EXP_W-1:0] bias;
  logic [22:0]             fmask;

  always_comb begin
    fw    = number_format ? 5'd23 : 5'd10;
    emin  = number_format ? EMIN32 : EMIN16;
    bias  = number_format ? BIAS32 : BIAS16;
    fmask = number_format ? 23'h7FFFFF : 23'h0003FF;
  end

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      number_format <= 1'b1;
      rounding_mode <= RM_RNE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FMT: number_format <= cfg_data[0];
        REG_RND: rounding_mode <= rm_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // flow control
  always_comb begin
    adv[NST-1] = !vld[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
    vld_in = {vld[NST-2:0], in_valid};
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (adv[i]) vld[i] <= vld_in[i];
      end
    end
  end

  // stage 1: decode
  always_comb begin
    op_t oa;
    op_t ob;
    oa = decode(operand_a, number_format);
    ob = decode(operand_b, number_format);
    s1_next.cmd = cmd_t'(cmd);
    s1_next.ca  = oa.cls;
    s1_next.cb  = ob.cls;
    s1_next.sa  = oa.sign;
    s1_next.sb  = ob.sign;
    s1_next.ea  = oa.exp;
    s1_next.eb  = ob.exp;
    s1_next.ma  = oa.sig;
    s1_next.mb  = ob.sig;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) s1 <= s1_next;
  end

  // stage 2: special cases, operand swap, product, first quotient bit
  always_comb begin
    logic                    sbe;
    logic                    sx;
    logic                    abig;
    logic signed [EXP_W-1:0] ediff;
    logic [47:0]             prod;
    logic                    q0;
    sbe  = s1.sb ^ (s1.cmd == CMD_SUB);
    sx   = s1.sa ^ s1.sb;
    abig = (s1.cb == CLS_ZERO) || ((s1.ca != CLS_ZERO) &&
           ((s1.ea > s1.eb) || ((s1.ea == s1.eb) && (s1.ma >= s1.mb))));
    ediff = abig ? (s1.ea - s1.eb) : (s1.eb - s1.ea);
    prod  = s1.ma * s1.mb;
    q0    = s1.ma >= s1.mb;

    s2_next.cmd   = s1.cmd;
    s2_next.spec  = 1'b0;
    s2_next.scls  = CLS_FIN;
    s2_next.ssign = 1'b0;
    if (s1.ca == CLS_NAN || s1.cb == CLS_NAN) begin
      s2_next.spec = 1'b1;
      s2_next.scls = CLS_NAN;
    end else begin
      case (s1.cmd)
        CMD_ADD, CMD_SUB: begin
          if (s1.ca == CLS_INF || s1.cb == CLS_INF) begin
            s2_next.spec = 1'b1;
            if (s1.ca == CLS_INF && s1.cb == CLS_INF && s1.sa != sbe) begin
              s2_next.scls = CLS_NAN;
            end else begin
              s2_next.scls  = CLS_INF;
              s2_next.ssign = (s1.ca == CLS_INF) ? s1.sa : sbe;
            end
          end else if (s1.ca == CLS_ZERO && s1.cb == CLS_ZERO) begin
            s2_next.spec  = 1'b1;
            s2_next.scls  = CLS_ZERO;
            s2_next.ssign = (s1.sa == sbe) ? s1.sa : (rounding_mode == RM_RDN);
          end
        end
        CMD_MUL: begin
          if ((s1.ca == CLS_ZERO && s1.cb == CLS_INF) ||
              (s1.ca == CLS_INF && s1.cb == CLS_ZERO)) begin
            s2_next.spec = 1'b1;
            s2_next.scls = CLS_NAN;
          end else if (s1.ca == CLS_INF || s1.cb == CLS_INF) begin
            s2_next.spec  = 1'b1;
            s2_next.scls  = CLS_INF;
            s2_next.ssign = sx;
          end else if (s1.ca == CLS_ZERO || s1.cb == CLS_ZERO) begin
            s2_next.spec  = 1'b1;
            s2_next.scls  = CLS_ZERO;
            s2_next.ssign = sx;
          end
        end
        default: begin
          if ((s1.ca == CLS_ZERO && s1.cb == CLS_ZERO) ||
              (s1.ca == CLS_INF && s1.cb == CLS_INF)) begin
            s2_next.spec = 1'b1;
            s2_next.scls = CLS_NAN;
          end else if (s1.ca == CLS_INF || s1.cb == CLS_ZERO) begin
            s2_next.spec  = 1'b1;
            s2_next.scls  = CLS_INF;
            s2_next.ssign = sx;
          end else if (s1.ca == CLS_ZERO || s1.cb == CLS_INF) begin
            s2_next.spec  = 1'b1;
            s2_next.scls  = CLS_ZERO;
            s2_next.ssign = sx;
          end
        end
      endcase
    end

    s2_next.sub = (s1.sa != sbe);
    s2_next.d   = (ediff > 11'sd63) ? 6'd63 : ediff[5:0];
    s2_next.y   = {(abig ? s1.mb : s1.ma), 24'd0};
    s2_next.dvs = s1.mb;
    s2_next.rem = q0 ? (s1.ma - s1.mb) : s1.ma;
    s2_next.quo = {{(Q_W-1){1'b0}}, q0};
    case (s1.cmd)
      CMD_ADD, CMD_SUB: begin
        s2_next.sign = abig ? s1.sa : sbe;
        s2_next.e    = (abig ? s1.ea : s1.eb) + 11'sd1;
        s2_next.acc  = {1'b0, (abig ? s1.ma : s1.mb), 24'd0};
      end
      CMD_MUL: begin
        s2_next.sign = sx;
        s2_next.e    = s1.ea + s1.eb + 11'sd1;
        s2_next.acc  = {1'b0, prod};
      end
      default: begin
        s2_next.sign = sx;
        s2_next.e    = s1.ea - s1.eb;
        s2_next.acc  = {1'b0, prod};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[1]) s2 <= s2_next;
  end

  // stages 3 to 9: divider steps, alignment and add in the first two
  assign mid_in[0] = s2;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_mid
    if (k > 0) begin : g_link
      assign mid_in[k] = mid_q[k-1];
    end

    always_comb begin
      mid_t        nx;
      logic [24:0] t;
      logic        qb;
      logic [47:0] lostm;
      nx = mid_in[k];
      for (int j = 0; j < DIV_STEPS; j++) begin
        t      = {nx.rem, 1'b0};
        qb     = t >= {1'b0, nx.dvs};
        nx.rem = qb ? 24'(t - {1'b0, nx.dvs}) : t[23:0];
        nx.quo = {nx.quo[Q_W-2:0], qb};
      end
      if (k == 0) begin
        lostm = (48'd1 << nx.d) - 48'd1;
        nx.y  = (nx.y >> nx.d) | {47'd0, |(nx.y & lostm)};
      end
      if (k == 1 && (nx.cmd == CMD_ADD || nx.cmd == CMD_SUB)) begin
        nx.acc = nx.sub ? (nx.acc - {1'b0, nx.y}) : (nx.acc + {1'b0, nx.y});
      end
      mid_d[k] = nx;
    end

    always_ff @(posedge clk) begin
      if (adv[2+k]) mid_q[k] <= mid_d[k];
    end
  end

  // stage 10: merge into a 64-bit frame
  always_comb begin
    mid_t m;
    m = mid_q[DIV_STAGES-1];
    s10_next.spec  = m.spec;
    s10_next.scls  = m.scls;
    s10_next.ssign = m.ssign;
    s10_next.sign  = m.sign;
    s10_next.e     = m.e;
    case (m.cmd)
      CMD_ADD, CMD_SUB: s10_next.n = {m.acc, 15'd0};
      CMD_MUL:          s10_next.n = {m.acc[47:0], 16'd0};
      default:          s10_next.n = {m.quo[Q_W-1:1], m.quo[0] | (m.rem != '0), 35'd0};
    endcase
    if (!m.spec && (m.cmd == CMD_ADD || m.cmd == CMD_SUB) && m.acc == '0) begin
      s10_next.spec  = 1'b1;
      s10_next.scls  = CLS_ZERO;
      s10_next.ssign = (rounding_mode == RM_RDN);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[9]) s10 <= s10_next;
  end

  // stages 11 and 12: normalize
  always_comb begin
    s11_next = s10;
    if (s11_next.n[63:32] == '0) begin
      s11_next.n = s11_next.n << 32;
      s11_next.e = s11_next.e - 11'sd32;
    end
    if (s11_next.n[63:48] == '0) begin
      s11_next.n = s11_next.n << 16;
      s11_next.e = s11_next.e - 11'sd16;
    end
    if (s11_next.n[63:56] == '0) begin
      s11_next.n = s11_next.n << 8;
      s11_next.e = s11_next.e - 11'sd8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[10]) s11 <= s11_next;
  end

  always_comb begin
    s12_next = s11;
    if (s12_next.n[63:60] == '0) begin
      s12_next.n = s12_next.n << 4;
      s12_next.e = s12_next.e - 11'sd4;
    end
    if (s12_next.n[63:62] == '0) begin
      s12_next.n = s12_next.n << 2;
      s12_next.e = s12_next.e - 11'sd2;
    end
    if (!s12_next.n[63]) begin
      s12_next.n = s12_next.n << 1;
      s12_next.e = s12_next.e - 11'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[11]) s12 <= s12_next;
  end

  // stage 13: round position, guard and sticky, increment decision
  always_comb begin
    logic                    sub;
    logic signed [EXP_W-1:0] sh;
    logic [11:0]             tt;
    logic                    big;
    logic [5:0]              t6;
    logic [63:0]             kf;
    logic [63:0]             mask;
    logic                    rbit;
    logic                    sticky;
    logic [23:0]             kept;
    logic                    any;
    logic                    gt;
    logic                    eq;
    sub    = s12.e < emin;
    sh     = sub ? (emin - s12.e) : 11'sd0;
    tt     = 12'd63 - {7'd0, fw} + {1'b0, sh};
    big    = tt > 12'd64;
    t6     = tt[5:0];
    kf     = s12.n >> t6;
    mask   = (64'd1 << (t6 - 6'd1)) - 64'd1;
    rbit   = big ? 1'b0 : s12.n[t6 - 6'd1];
    sticky = big ? 1'b1 : ((s12.n & mask) != '0);
    kept   = (tt > 12'd63) ? 24'd0 : kf[23:0];
    any    = rbit || sticky;
    gt     = rbit && sticky;
    eq     = rbit && !sticky;
    s13_next.spec  = s12.spec;
    s13_next.scls  = s12.scls;
    s13_next.ssign = s12.ssign;
    s13_next.sign  = s12.sign;
    s13_next.sub   = sub;
    s13_next.e     = s12.e;
    s13_next.kept  = kept;
    case (rounding_mode)
      RM_RNE:  s13_next.inc = gt || (eq && kept[0]);
      RM_RUP:  s13_next.inc = any && !s12.sign;
      RM_RDN:  s13_next.inc = any && s12.sign;
      default: s13_next.inc = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[12]) s13 <= s13_next;
  end

  // stage 14: increment, carry out, overflow
  always_comb begin
    logic [24:0] k2;
    logic        carry;
    k2    = {1'b0, s13.kept} + {24'd0, s13.inc};
    carry = !s13.sub && (number_format ? k2[24] : k2[11]);
    s14_next.spec  = s13.spec;
    s14_next.scls  = s13.scls;
    s14_next.ssign = s13.ssign;
    s14_next.sign  = s13.sign;
    s14_next.sub   = s13.sub;
    s14_next.e     = carry ? (s13.e + 11'sd1) : s13.e;
    s14_next.k2    = carry ? (k2 >> 1) : k2;
    s14_next.ovf   = !s13.sub && (s14_next.e > bias);
    s14_next.p     = msb25(s14_next.k2);
  end

  always_ff @(posedge clk) begin
    if (adv[13]) s14 <= s14_next;
  end

  // stage 15: output word
  always_ff @(posedge clk) begin
    logic                    trunc;
    logic signed [EXP_W-1:0] es;
    trunc = (rounding_mode == RM_RTZ) || (rounding_mode == RM_RUP && s14.sign) ||
            (rounding_mode == RM_RDN && !s14.sign);
    es    = emin - $signed({6'd0, fw}) + $signed({6'd0, s14.p});
    if (adv[14]) begin
      if (s14.spec) begin
        result_class    <= s14.scls;
        result_sign     <= (s14.scls == CLS_NAN) ? 1'b0 : s14.ssign;
        result_exponent <= '0;
        result_fraction <= '0;
      end else if (!s14.sub) begin
        result_sign <= s14.sign;
        if (s14.ovf && trunc) begin
          result_class    <= CLS_FIN;
          result_exponent <= bias[8:0];
          result_fraction <= fmask;
        end else if (s14.ovf) begin
          result_class    <= CLS_INF;
          result_exponent <= '0;
          result_fraction <= '0;
        end else begin
          result_class    <= CLS_FIN;
          result_exponent <= s14.e[8:0];
          result_fraction <= s14.k2[22:0] & fmask;
        end
      end else begin
        result_sign <= s14.sign;
        if (s14.k2 == '0) begin
          result_class    <= CLS_ZERO;
          result_exponent <= '0;
          result_fraction <= '0;
        end else if (s14.p >= fw) begin
          result_class    <= CLS_FIN;
          result_exponent <= emin[8:0];
          result_fraction <= s14.k2[22:0] & fmask;
        end else begin
          result_class    <= CLS_FIN;
          result_exponent <= es[8:0];
          result_fraction <= 23'(s14.k2 << (fw - s14.p)) & fmask;
        end
      end
    end
  end

`ifndef SYNTH
  a_nan_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_class == CLS_NAN |-> !result_sign)
    else $error("nan word with sign set");

  a_special_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_class != CLS_FIN |-> result_exponent == '0 && result_fraction == '0)
    else $error("special word with nonzero exponent or fraction");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> !in_stall)
    else $error("input stalled with first stage empty");
`endif

endmodule
